### hw/rtl/mtcd_pkg.sv
// ----------------------------------------------------------------------------
// mtcd_pkg - shared types and constants of the crank wheel decoder
// Register layout, request codes, field widths and fixed-point constants.
// ----------------------------------------------------------------------------
package mtcd_pkg;

   localparam int RING_DEPTH_DEF = 128;
   localparam int TIME_WIDTH_DEF = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam int TEETH_W   = 6;
   localparam int MISSING_W = 3;
   localparam int ANGLE_W   = 25;
   localparam int TICKS_W   = 32;
   localparam int SPEED_W   = 40;
   localparam int EVTIME_W  = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;
   localparam int DPP_W     = 24;

   localparam int unsigned TURN_DEG    = 360;
   localparam int unsigned TURN_Q16    = 23592960;
   localparam int unsigned MANY_TEETH  = 6;
   localparam int unsigned SPEED_SCALE = TURN_DEG * 256;
   localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

   localparam logic [TEETH_W-1:0]   TEETH_TOTAL_RST   = 6'd36;
   localparam logic [MISSING_W-1:0] TEETH_MISSING_RST = 3'd1;
   localparam logic [TICKS_W-1:0]   TICKS_RST         = 32'd1000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEETH_TOTAL   = 3'd0,
      CSR_TEETH_MISSING = 3'd1,
      CSR_TOOTH_WIDTH   = 3'd2,
      CSR_FIRST_ANGLE   = 3'd3,
      CSR_TICKS_PER_SEC = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef struct packed {
      logic [TEETH_W-1:0]   teeth_total;
      logic [MISSING_W-1:0] teeth_missing;
      logic [ANGLE_W-1:0]   tooth_width_deg;
      logic [ANGLE_W-1:0]   first_tooth_angle;
      logic [TICKS_W-1:0]   ticks_per_second;
   } cfg_type;

endpackage

### hw/rtl/mtcd_div.sv
// ----------------------------------------------------------------------------
// mtcd_div - shared restoring divider
// One quotient bit per cycle; quotient and remainder hold until next start.
// ----------------------------------------------------------------------------
module mtcd_div #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic             ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(shifted - {1'b0, den_ff}) : DEN_W'(shifted);
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;
endmodule

### hw/rtl/mtcd_front.sv
// ----------------------------------------------------------------------------
// mtcd_front - request intake and configuration registers
// Holds the wheel configuration and a short request queue to the back end.
// ----------------------------------------------------------------------------
module mtcd_front #(
   parameter int TIME_WIDTH = mtcd_pkg::TIME_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_operation,
   input  logic [mtcd_pkg::EVTIME_W-1:0]  req_event_time,
   input  logic                           req_pin_level,
   input  logic                           csr_we,
   input  logic [mtcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mtcd_pkg::CSR_DAT_W-1:0] csr_wdata,
   output mtcd_pkg::cfg_type              cfg,
   output logic                           q_valid,
   output logic                           q_op,
   output logic [TIME_WIDTH-1:0]          q_time,
   output logic                           q_level,
   input  logic                           q_pop
);
   import mtcd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cfg_type               cfg_ff, cfg_in;
   logic                  op_ff   [QUEUE_DEPTH];
   logic [TIME_WIDTH-1:0] time_ff [QUEUE_DEPTH];
   logic                  lvl_ff  [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  full;
   logic                  push;

   assign full = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign busy = full | reset;
   assign push = start & ~busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TEETH_TOTAL:   cfg_in.teeth_total       = csr_wdata[TEETH_W-1:0];
            CSR_TEETH_MISSING: cfg_in.teeth_missing     = csr_wdata[MISSING_W-1:0];
            CSR_TOOTH_WIDTH:   cfg_in.tooth_width_deg   = csr_wdata[ANGLE_W-1:0];
            CSR_FIRST_ANGLE:   cfg_in.first_tooth_angle = csr_wdata[ANGLE_W-1:0];
            CSR_TICKS_PER_SEC: cfg_in.ticks_per_second  = csr_wdata[TICKS_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push) - CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= '{TEETH_TOTAL_RST, TEETH_MISSING_RST, '0, '0, TICKS_RST};
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cfg_ff    <= cfg_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         op_ff[wr_ptr_ff]   <= req_operation;
         time_ff[wr_ptr_ff] <= TIME_WIDTH'(req_event_time);
         lvl_ff[wr_ptr_ff]  <= req_pin_level;
      end
   end

   assign cfg     = cfg_ff;
   assign q_valid = cnt_ff != '0;
   assign q_op    = op_ff[rd_ptr_ff];
   assign q_time  = time_ff[rd_ptr_ff];
   assign q_level = lvl_ff[rd_ptr_ff];
endmodule

### hw/rtl/mtcd_back.sv
// ----------------------------------------------------------------------------
// mtcd_back - edge ring and query sequencer
// Logs edges into the ring, walks it for queries and computes angle and speed.
// ----------------------------------------------------------------------------
module mtcd_back #(
   parameter int RING_DEPTH = mtcd_pkg::RING_DEPTH_DEF,
   parameter int TIME_WIDTH = mtcd_pkg::TIME_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mtcd_pkg::cfg_type             cfg,
   input  logic                          q_valid,
   input  logic                          q_op,
   input  logic [TIME_WIDTH-1:0]         q_time,
   input  logic                          q_level,
   output logic                          q_pop,
   output logic                          rsp_strobe,
   output logic                          rsp_synced,
   output logic [mtcd_pkg::ANGLE_W-1:0]  rsp_angle_out,
   output logic [mtcd_pkg::SPEED_W-1:0]  rsp_speed_out,
   output logic [mtcd_pkg::EVTIME_W-1:0] rsp_query_time
);
   import mtcd_pkg::*;

   localparam int IDX_W  = $clog2(RING_DEPTH);
   localparam int FILL_W = $clog2(RING_DEPTH + 1);
   localparam int FTA_W  = $clog2(2 * RING_DEPTH + 16);
   localparam int NUM_W  = (TIME_WIDTH > 49) ? TIME_WIDTH : 49;
   localparam int DEN_W  = (TIME_WIDTH > ANGLE_W) ? TIME_WIDTH : ANGLE_W;
   localparam int BASE_W = FTA_W - 1 + DPP_W + 2;
   localparam int POS_W  = BASE_W + 1;
   localparam int PROD_W = 49;
   localparam int KMUL_W = TIME_WIDTH + 4;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_WALK, S_WALK_D,
      S_GAP_CHK, S_GAP_RE, S_GAP_R2, S_GAP_R4, S_GAP_CMP, S_CORR,
      S_UNI_SPAN, S_UNI_SCAN, S_UNI_SCAN_D,
      S_REV, S_REV_L, S_REV_R,
      S_DPP, S_BASE, S_SCALE_SET, S_SCALE, S_POS, S_ANGLE,
      S_SPD_MUL, S_SPD, S_FIN, S_DIV_WAIT
   } state_type;

   function automatic logic [IDX_W-1:0] mod_d(input logic [FTA_W-1:0] n);
      logic [FTA_W-1:0] v;
      v = n;
      for (int k = 0; k < 4; k++)
         if (v >= FTA_W'(RING_DEPTH)) v = v - FTA_W'(RING_DEPTH);
      return v[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] back_i(input logic [IDX_W-1:0] i,
                                                input logic [FTA_W-1:0] n);
      logic [IDX_W-1:0] m;
      logic [IDX_W:0]   s;
      m = mod_d(n);
      s = {1'b0, i} + (IDX_W+1)'(RING_DEPTH) - {1'b0, m};
      if (s >= (IDX_W+1)'(RING_DEPTH)) s = s - (IDX_W+1)'(RING_DEPTH);
      return s[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] fwd_i(input logic [IDX_W-1:0] i,
                                               input logic [FTA_W-1:0] n);
      logic [IDX_W-1:0] m;
      logic [IDX_W:0]   s;
      m = mod_d(n);
      s = {1'b0, i} + {1'b0, m};
      if (s >= (IDX_W+1)'(RING_DEPTH)) s = s - (IDX_W+1)'(RING_DEPTH);
      return s[IDX_W-1:0];
   endfunction

   // slot i has been written once fill reaches i, slot 0 only after a full lap
   function automatic logic valid_i(input logic [IDX_W-1:0] i,
                                    input logic [FILL_W-1:0] fill);
      if (i == '0) return fill == FILL_W'(RING_DEPTH);
      return fill >= FILL_W'(i);
   endfunction

   function automatic logic before_t(input logic [TIME_WIDTH-1:0] a,
                                     input logic [TIME_WIDTH-1:0] b);
      logic [TIME_WIDTH-1:0] d;
      d = a - b;
      return d[TIME_WIDTH-1];
   endfunction

   logic [TIME_WIDTH:0] ring_mem [RING_DEPTH];
   logic [TIME_WIDTH:0] mem_q_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    rd_addr;

   state_type             state_ff, state_in, ret_ff, ret_in;
   logic [IDX_W-1:0]      newest_ff, newest_in, ftp_ff, ftp_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [IDX_W-1:0]      last_ff, last_in, start_ff, start_in;
   logic [FTA_W-1:0]      fta_ff, fta_in;
   logic [TIME_WIDTH-1:0] tick_ff, tick_in, te_ff, te_in, tm2_ff, tm2_in, tm4_ff, tm4_in;
   logic [TIME_WIDTH-1:0] pulse_ff, pulse_in, prev_ff, prev_in, tl_ff, tl_in;
   logic [TIME_WIDTH-1:0] period_ff, period_in, dt_ff, dt_in, r_ff, r_in;
   logic [TIME_WIDTH-1:0] srem_ff, srem_in;
   logic [ANGLE_W-1:0]    sq_ff, sq_in, angle_ff, angle_in;
   logic [4:0]            sbit_ff, sbit_in;
   logic                  sph_ff, sph_in, first_ff, first_in;
   logic [BASE_W-1:0]     base_ff, base_in;
   logic [POS_W-1:0]      wrap_ff, wrap_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;

   logic                  strobe_ff, strobe_in, synced_ff, synced_in;
   logic [ANGLE_W-1:0]    out_angle_ff, out_angle_in;
   logic [SPEED_W-1:0]    out_speed_ff, out_speed_in;
   logic [EVTIME_W-1:0]   out_time_ff, out_time_in;

   logic                  div_start, div_done;
   logic [NUM_W-1:0]      div_num, div_quo;
   logic [DEN_W-1:0]      div_den, div_rem;

   mtcd_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[newest_in] <= {q_level, q_time};
      mem_q_ff <= ring_mem[rd_addr];
   end

   always_comb begin
      logic [TIME_WIDTH-1:0] mem_time, sd, per;
      logic                  mem_lvl, fail, ok;
      logic [IDX_W-1:0]      e_idx, m2_idx, m4_idx, rev_idx, ftp_back, nl;
      logic [FTA_W-1:0]      two_p, skip, ending, over, span;
      logic [TEETH_W-1:0]    present;
      logic [KMUL_W-1:0]     rhs;
      logic [POS_W-1:0]      pos;
      logic [PROD_W-1:0]     spd_q;

      mem_time = mem_q_ff[TIME_WIDTH-1:0];
      mem_lvl  = mem_q_ff[TIME_WIDTH];
      fail     = 1'b0;
      present  = cfg.teeth_total - TEETH_W'(cfg.teeth_missing);
      two_p    = FTA_W'(present) << 1;
      span     = FTA_W'(cfg.teeth_total) << 1;
      skip     = (present > TEETH_W'(MANY_TEETH)) ? FTA_W'(4) : FTA_W'(2);
      ending   = two_p - FTA_W'(3);
      e_idx    = back_i(last_ff, fta_ff);
      m2_idx   = back_i(last_ff, fta_ff + FTA_W'(2));
      m4_idx   = back_i(last_ff, fta_ff + FTA_W'(4));
      rev_idx  = back_i(last_ff, two_p);
      ftp_back = back_i(last_ff, FTA_W'(ftp_ff));
      nl       = back_i(last_ff, FTA_W'(1));
      over     = '0;
      ok       = 1'b0;
      sd       = '0;
      per      = mem_time;
      rhs      = KMUL_W'(prev_ff) * (KMUL_W'(cfg.teeth_missing) + KMUL_W'(2));
      pos      = POS_W'(base_ff) + POS_W'(sq_ff);
      spd_q    = PROD_W'(div_quo);

      state_in  = state_ff;
      ret_in    = ret_ff;
      newest_in = newest_ff;
      ftp_in    = ftp_ff;
      fill_in   = fill_ff;
      last_in   = last_ff;
      start_in  = start_ff;
      fta_in    = fta_ff;
      tick_in   = tick_ff;
      te_in     = te_ff;
      tm2_in    = tm2_ff;
      tm4_in    = tm4_ff;
      pulse_in  = pulse_ff;
      prev_in   = prev_ff;
      tl_in     = tl_ff;
      period_in = period_ff;
      dt_in     = dt_ff;
      r_in      = r_ff;
      srem_in   = srem_ff;
      sq_in     = sq_ff;
      sbit_in   = sbit_ff;
      sph_in    = sph_ff;
      first_in  = first_ff;
      base_in   = base_ff;
      wrap_in   = wrap_ff;
      prod_in   = prod_ff;
      angle_in  = angle_ff;

      strobe_in    = 1'b0;
      synced_in    = synced_ff;
      out_angle_in = out_angle_ff;
      out_speed_in = out_speed_ff;
      out_time_in  = out_time_ff;

      q_pop     = 1'b0;
      mem_we    = 1'b0;
      rd_addr   = last_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_op == OP_RECORD) begin
                  newest_in = fwd_i(newest_ff, FTA_W'(1));
                  mem_we    = 1'b1;
                  if (fill_ff != FILL_W'(RING_DEPTH)) fill_in = fill_ff + 1'b1;
               end else begin
                  tick_in  = q_time;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (cfg.teeth_total < TEETH_W'(2) ||
                (7'(cfg.teeth_missing) + 7'd2) > 7'(cfg.teeth_total) ||
                !valid_i(newest_ff, fill_ff)) begin
               fail = 1'b1;
            end else begin
               last_in  = newest_ff;
               start_in = newest_ff;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            rd_addr  = last_ff;
            state_in = S_WALK_D;
         end
         S_WALK_D: begin
            if (before_t(tick_ff, mem_time)) begin
               if (!valid_i(nl, fill_ff) || nl == start_ff) begin
                  fail = 1'b1;
               end else begin
                  last_in  = nl;
                  state_in = S_WALK;
               end
            end else begin
               fta_in = '0;
               if (mem_lvl) begin
                  if (cfg.tooth_width_deg != '0) fta_in = FTA_W'(1);
                  else last_in = nl;
               end
               first_in = 1'b1;
               state_in = (cfg.teeth_missing != '0) ? S_GAP_CHK : S_UNI_SPAN;
            end
         end
         S_GAP_CHK: begin
            if (!valid_i(e_idx, fill_ff) || !valid_i(m2_idx, fill_ff) ||
                !valid_i(m4_idx, fill_ff) || fta_ff >= FTA_W'(RING_DEPTH + 4)) begin
               fail = 1'b1;
            end else if (first_ff) begin
               rd_addr  = e_idx;
               state_in = S_GAP_RE;
            end else begin
               rd_addr  = m4_idx;
               state_in = S_GAP_R4;
            end
         end
         S_GAP_RE: begin
            te_in    = mem_time;
            rd_addr  = m2_idx;
            state_in = S_GAP_R2;
         end
         S_GAP_R2: begin
            tm2_in   = mem_time;
            rd_addr  = m4_idx;
            state_in = S_GAP_R4;
         end
         S_GAP_R4: begin
            tm4_in   = mem_time;
            pulse_in = te_ff - tm2_ff;
            prev_in  = tm2_ff - mem_time;
            state_in = S_GAP_CMP;
         end
         S_GAP_CMP: begin
            // gap when twice the pulse beats the previous pulse times missing+2
            if (KMUL_W'({pulse_ff, 1'b0}) > rhs) begin
               state_in = S_CORR;
            end else begin
               fta_in   = fta_ff + FTA_W'(2);
               te_in    = tm2_ff;
               tm2_in   = tm4_ff;
               first_in = 1'b0;
               state_in = S_GAP_CHK;
            end
         end
         S_CORR: begin
            state_in = S_REV;
            if (fta_ff < skip) begin
               last_in = back_i(last_ff, fta_ff + skip);
               fta_in  = two_p - skip;
            end else if (fta_ff > ending) begin
               over = fta_ff - ending + skip;
               if (cfg.tooth_width_deg == '0 && over[0]) over = over - 1'b1;
               if (over > fta_ff) begin
                  fail = 1'b1;
               end else begin
                  last_in = back_i(last_ff, over);
                  fta_in  = fta_ff - over;
               end
            end
         end
         S_UNI_SPAN: begin
            if (FTA_W'(ftp_back) > span + FTA_W'(1)) ftp_in = fwd_i(ftp_ff, span);
            else state_in = S_UNI_SCAN;
         end
         S_UNI_SCAN: begin
            rd_addr  = ftp_ff;
            state_in = S_UNI_SCAN_D;
         end
         S_UNI_SCAN_D: begin
            ok = valid_i(ftp_ff, fill_ff) && !mem_lvl;
            if (ftp_back == '0) begin
               if (!ok) fail = 1'b1;
               else state_in = S_REV;
            end else if (ok) begin
               fta_in   = fta_ff + FTA_W'(ftp_back);
               state_in = S_REV;
            end else begin
               ftp_in   = fwd_i(ftp_ff, FTA_W'(1));
               state_in = S_UNI_SCAN;
            end
         end
         S_REV: begin
            if (!valid_i(last_ff, fill_ff) || !valid_i(rev_idx, fill_ff)) begin
               fail = 1'b1;
            end else begin
               rd_addr  = last_ff;
               state_in = S_REV_L;
            end
         end
         S_REV_L: begin
            tl_in    = mem_time;
            rd_addr  = rev_idx;
            state_in = S_REV_R;
         end
         S_REV_R: begin
            per = tl_ff - mem_time;
            if (before_t(tl_ff, mem_time) || per == '0) begin
               fail = 1'b1;
            end else begin
               period_in = per;
               dt_in     = tick_ff - tl_ff;
               state_in  = S_DPP;
            end
         end
         S_DPP: begin
            // degrees per tooth, rounded
            div_start = 1'b1;
            div_num   = NUM_W'(TURN_Q16) + NUM_W'(cfg.teeth_total >> 1);
            div_den   = DEN_W'(cfg.teeth_total);
            ret_in    = S_BASE;
            state_in  = S_DIV_WAIT;
         end
         S_BASE: begin
            base_in = BASE_W'(fta_ff >> 1) * BASE_W'(DPP_W'(div_quo))
                      + (fta_ff[0] ? BASE_W'(cfg.tooth_width_deg) : '0)
                      + BASE_W'(cfg.first_tooth_angle);
            div_start = 1'b1;
            div_num   = NUM_W'(dt_ff);
            div_den   = DEN_W'(period_ff);
            ret_in    = S_SCALE_SET;
            state_in  = S_DIV_WAIT;
         end
         S_SCALE_SET: begin
            r_in     = TIME_WIDTH'(div_rem);
            srem_in  = '0;
            sq_in    = '0;
            sbit_in  = 5'd31;
            sph_in   = 1'b0;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            // floor(r*turn/period), doubling then conditional add per bit
            if (!sph_ff) begin
               sd = period_ff - srem_ff;
               if (srem_ff >= sd) begin
                  srem_in = srem_ff - sd;
                  sq_in   = {sq_ff[ANGLE_W-2:0], 1'b1};
               end else begin
                  srem_in = srem_ff << 1;
                  sq_in   = {sq_ff[ANGLE_W-2:0], 1'b0};
               end
               sph_in = 1'b1;
            end else begin
               sd = period_ff - r_ff;
               if (TURN_Q16[sbit_ff]) begin
                  if (srem_ff >= sd) begin
                     srem_in = srem_ff - sd;
                     sq_in   = sq_ff + 1'b1;
                  end else begin
                     srem_in = srem_ff + r_ff;
                  end
               end
               sph_in = 1'b0;
               if (sbit_ff == '0) state_in = S_POS;
               else sbit_in = sbit_ff - 1'b1;
            end
         end
         S_POS: begin
            if (pos == '0) begin
               angle_in = (dt_ff >= period_ff) ? ANGLE_W'(TURN_Q16) : '0;
               state_in = S_SPD_MUL;
            end else begin
               wrap_in  = pos - 1'b1;
               state_in = S_ANGLE;
            end
         end
         S_ANGLE: begin
            // remove one whole turn per cycle, exactly one turn stays a turn
            if (wrap_ff >= POS_W'(TURN_Q16)) begin
               wrap_in = wrap_ff - POS_W'(TURN_Q16);
            end else begin
               angle_in = ANGLE_W'(wrap_ff) + 1'b1;
               state_in = S_SPD_MUL;
            end
         end
         S_SPD_MUL: begin
            prod_in  = PROD_W'(SPEED_SCALE) * PROD_W'(cfg.ticks_per_second);
            state_in = S_SPD;
         end
         S_SPD: begin
            div_start = 1'b1;
            div_num   = NUM_W'(prod_ff);
            div_den   = DEN_W'(period_ff);
            ret_in    = S_FIN;
            state_in  = S_DIV_WAIT;
         end
         S_FIN: begin
            strobe_in    = 1'b1;
            synced_in    = 1'b1;
            out_angle_in = angle_ff;
            out_speed_in = (spd_q > PROD_W'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(spd_q);
            out_time_in  = EVTIME_W'(tick_ff);
            state_in     = S_IDLE;
         end
         S_DIV_WAIT: begin
            if (div_done) state_in = ret_ff;
         end
         default: state_in = S_IDLE;
      endcase

      if (fail) begin
         strobe_in    = 1'b1;
         synced_in    = 1'b0;
         out_angle_in = '0;
         out_speed_in = '0;
         out_time_in  = EVTIME_W'(tick_ff);
         state_in     = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         newest_ff <= '0;
         ftp_ff    <= '0;
         fill_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         newest_ff <= newest_in;
         ftp_ff    <= ftp_in;
         fill_ff   <= fill_in;
         strobe_ff <= strobe_in;
      end
      last_ff      <= last_in;
      start_ff     <= start_in;
      fta_ff       <= fta_in;
      tick_ff      <= tick_in;
      te_ff        <= te_in;
      tm2_ff       <= tm2_in;
      tm4_ff       <= tm4_in;
      pulse_ff     <= pulse_in;
      prev_ff      <= prev_in;
      tl_ff        <= tl_in;
      period_ff    <= period_in;
      dt_ff        <= dt_in;
      r_ff         <= r_in;
      srem_ff      <= srem_in;
      sq_ff        <= sq_in;
      sbit_ff      <= sbit_in;
      sph_ff       <= sph_in;
      first_ff     <= first_in;
      base_ff      <= base_in;
      wrap_ff      <= wrap_in;
      prod_ff      <= prod_in;
      angle_ff     <= angle_in;
      synced_ff    <= synced_in;
      out_angle_ff <= out_angle_in;
      out_speed_ff <= out_speed_in;
      out_time_ff  <= out_time_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_synced     = synced_ff;
   assign rsp_angle_out  = out_angle_ff;
   assign rsp_speed_out  = out_speed_ff;
   assign rsp_query_time = out_time_ff;
endmodule

### hw/rtl/missing_tooth_crank_decoder.sv
// ----------------------------------------------------------------------------
// missing_tooth_crank_decoder - crank wheel position and speed decoder
// Logs sensor edges in a ring and answers position requests with angle/speed.
// ----------------------------------------------------------------------------
// sequence: an edge request is written to the ring from the queue head in the idle state;
//    a position request walks back over edges, searches teeth for the gap or scans slots on
//    a uniform wheel, scales the angle, runs three divisions in the divider and takes whole
//    turns off the angle; the result strobe is registered
// throughput: one request at a time in the back end; a two-entry queue takes requests until full
// reset clears queue, newest index, fill count, first-tooth pointer; config takes reset values
module missing_tooth_crank_decoder #(
   parameter int RING_DEPTH = mtcd_pkg::RING_DEPTH_DEF,
   parameter int TIME_WIDTH = mtcd_pkg::TIME_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_operation,
   input  logic [mtcd_pkg::EVTIME_W-1:0]  req_event_time,
   input  logic                           req_pin_level,
   output logic                           rsp_strobe,
   output logic                           rsp_synced,
   output logic [mtcd_pkg::ANGLE_W-1:0]   rsp_angle_out,
   output logic [mtcd_pkg::SPEED_W-1:0]   rsp_speed_out,
   output logic [mtcd_pkg::EVTIME_W-1:0]  rsp_query_time,
   input  logic                           csr_we,
   input  logic [mtcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mtcd_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import mtcd_pkg::*;

   // wheel configuration; the user must write it only while idle, the block does not enforce this
   cfg_type               cfg;
   // head of the request queue
   logic                  q_valid;
   logic                  q_op;
   logic [TIME_WIDTH-1:0] q_time;
   logic                  q_level;
   logic                  q_pop;

   // front end: configuration registers and request queue
   mtcd_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_event_time (req_event_time),
      .req_pin_level  (req_pin_level),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cfg            (cfg),
      .q_valid        (q_valid),
      .q_op           (q_op),
      .q_time         (q_time),
      .q_level        (q_level),
      .q_pop          (q_pop)
   );

   // back end: edge ring, gap search, divider and result register
   // ring entries get no clearing pass: the fill count marks written slots
   mtcd_back #(.RING_DEPTH(RING_DEPTH), .TIME_WIDTH(TIME_WIDTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_valid        (q_valid),
      .q_op           (q_op),
      .q_time         (q_time),
      .q_level        (q_level),
      .q_pop          (q_pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_synced     (rsp_synced),
      .rsp_angle_out  (rsp_angle_out),
      .rsp_speed_out  (rsp_speed_out),
      .rsp_query_time (rsp_query_time)
   );
endmodule

### hw/rtl/mtcd_checker.sv
// ----------------------------------------------------------------------------
// mtcd_checker - port-level checks of the crank wheel decoder
// Watches the result strobe and fields over time; bound to the top level.
// ----------------------------------------------------------------------------
module mtcd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           busy,
   input logic                           rsp_strobe,
   input logic                           rsp_synced,
   input logic [mtcd_pkg::ANGLE_W-1:0]   rsp_angle_out,
   input logic [mtcd_pkg::SPEED_W-1:0]   rsp_speed_out
);
   import mtcd_pkg::*;

   // results come from a multi-cycle sequence, never on adjacent cycles
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe on two adjacent cycles");

   a_unsynced_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_synced) |-> (rsp_angle_out == '0 && rsp_speed_out == '0))
      else $error("unsynced result carries angle or speed");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_synced) |-> (rsp_angle_out <= ANGLE_W'(TURN_Q16)))
      else $error("angle beyond one turn");

   // first cycle out of reset: busy low and no result strobe
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (reset || (!busy && !rsp_strobe)))
      else $error("busy or strobe after reset");
endmodule

bind missing_tooth_crank_decoder mtcd_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_synced    (rsp_synced),
   .rsp_angle_out (rsp_angle_out),
   .rsp_speed_out (rsp_speed_out)
);
